FILE: design/snpm_pkg.sv
// Package for the sparse nonzero pixel marker.
// Holds field widths, register indexes and reset values; no dependencies.
package snpm_pkg;

   localparam int COORD_W    = 32;      // matrix row / column
   localparam int STEP_W     = 16;      // collapse step register
   localparam int SIDE_W     = 13;      // image width / height registers
   localparam int PIX_W      = 12;      // pixel row / column result
   localparam int IDX_W      = 20;      // pixel index result
   localparam int OFS_W      = 22;      // byte offset result
   localparam int PROD_W     = 25;      // full pixel index, row * width + column
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   localparam logic [SIDE_W-1:0] SIDE_LIMIT = 13'd4096;

   localparam logic [STEP_W-1:0] STEP_RESET   = 16'd1;
   localparam logic [SIDE_W-1:0] WIDTH_RESET  = 13'd1024;
   localparam logic [SIDE_W-1:0] HEIGHT_RESET = 13'd1024;

   // bitmap words: one memory row holds this many pixel flags
   localparam int SEEN_WIDTH = 32;
   localparam int SEEN_SHIFT = 5;

   localparam int MAX_PIXELS_DEF = 1048576;
   localparam int CHANNELS_DEF   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP   = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2,
      CSR_NONE   = 2'd3
   } csr_index_type;

endpackage

FILE: design/snpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the pixel occupancy bitmap.
module snpm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sparse_nonzero_pixel_marker_core.sv
// Sparse nonzero pixel marker: coarse pixel of each nonzero, first hit emits a result.
// Depends on snpm_pkg and snpm_ram (occupancy bitmap).
// Each word runs through the 32-step restoring divider, the multiply, the bitmap read and
// the bitmap update; words outside the image end after the multiply, words beyond the bitmap
// after the read. A new word is accepted only in idle, and the update stalls while a result waits.
// Reset: synchronous; control and CSR registers return to reset values, then a clearing pass
// zeroes the bitmap row by row while req_tready stays low.
module sparse_nonzero_pixel_marker_core
   import snpm_pkg::*;
#(
   parameter int MAX_PIXELS = MAX_PIXELS_DEF,
   parameter int CHANNELS   = CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // elem_row [31:0], elem_col [63:32]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // pixel_row [11:0], pixel_col [23:12], pixel_index [43:24],
   // byte_offset [65:44], zero [71:66]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROWS   = (MAX_PIXELS + SEEN_WIDTH - 1) / SEEN_WIDTH;
   localparam int ADDR_W = $clog2(ROWS);
   localparam int CNT_W  = $clog2(COORD_W);
   localparam int CH_W   = $clog2(CHANNELS + 1);
   localparam int BO_W   = PROD_W + CH_W;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_DIV    = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_LOOK   = 6'b010000,
      ST_UPDATE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [STEP_W-1:0]  step_ff;
   logic [SIDE_W-1:0]  width_ff, height_ff;
   logic [SIDE_W-1:0]  w_eff, h_eff;

   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [STEP_W-1:0]  div_ff, div_in;
   logic [COORD_W-1:0] qrow_ff, qrow_in, qcol_ff, qcol_in;
   logic [STEP_W-1:0]  rrow_ff, rrow_in, rcol_ff, rcol_in;
   logic [PIX_W-1:0]   prow_ff, prow_in, pcol_ff, pcol_in;
   logic [PROD_W-1:0]  idx_ff, idx_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                  ram_we, ram_re;
   logic [ADDR_W-1:0]     ram_waddr, row_addr;
   logic [SEEN_WIDTH-1:0] ram_wdata, ram_rdata, bit_mask;
   logic                  hit, out_free, out_range, too_big, load_out;
   logic [BO_W-1:0]       byte_full;

   // one restoring division step: returns {remainder, shifted quotient}
   function automatic logic [STEP_W+COORD_W-1:0] div_step(
      input logic [STEP_W-1:0]  rem,
      input logic [COORD_W-1:0] q,
      input logic [STEP_W-1:0]  d
   );
      logic [STEP_W:0] sh;
      logic [STEP_W:0] diff;
      sh   = {rem, q[COORD_W-1]};
      diff = sh - {1'b0, d};
      if (sh >= {1'b0, d}) begin
         return {diff[STEP_W-1:0], q[COORD_W-2:0], 1'b1};
      end
      return {sh[STEP_W-1:0], q[COORD_W-2:0], 1'b0};
   endfunction

   assign w_eff = (width_ff  > SIDE_LIMIT) ? SIDE_LIMIT : width_ff;
   assign h_eff = (height_ff > SIDE_LIMIT) ? SIDE_LIMIT : height_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign out_range = (qrow_ff >= {{(COORD_W-SIDE_W){1'b0}}, h_eff}) ||
                      (qcol_ff >= {{(COORD_W-SIDE_W){1'b0}}, w_eff});
   assign too_big   = (idx_ff >= PROD_W'(MAX_PIXELS));
   assign row_addr  = idx_ff[SEEN_SHIFT +: ADDR_W];
   assign bit_mask  = SEEN_WIDTH'(1) << idx_ff[SEEN_SHIFT-1:0];
   assign hit       = |(ram_rdata & bit_mask);
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign load_out  = (state_ff == ST_UPDATE) && !hit && out_free;
   assign byte_full = BO_W'(idx_ff) * BO_W'(CHANNELS);

   assign ram_re    = (state_ff == ST_LOOK) && !too_big;
   assign ram_we    = (state_ff == ST_CLEAR) || load_out;
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_ff : row_addr;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : (ram_rdata | bit_mask);

   snpm_ram #(
      .WIDTH  (SEEN_WIDTH),
      .DEPTH  (ROWS),
      .ADDR_W (ADDR_W)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (row_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      div_in        = div_ff;
      qrow_in       = qrow_ff;
      qcol_in       = qcol_ff;
      rrow_in       = rrow_ff;
      rcol_in       = rcol_ff;
      prow_in       = prow_ff;
      pcol_in       = pcol_ff;
      idx_in        = idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               qrow_in  = req_tdata[COORD_W-1:0];
               qcol_in  = req_tdata[2*COORD_W-1:COORD_W];
               rrow_in  = '0;
               rcol_in  = '0;
               cnt_in   = '0;
               div_in   = (step_ff == '0) ? STEP_W'(1) : step_ff;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            {rrow_in, qrow_in} = div_step(rrow_ff, qrow_ff, div_ff);
            {rcol_in, qcol_in} = div_step(rcol_ff, qcol_ff, div_ff);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(COORD_W - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // zero-size images fall out here as well
            if (out_range) begin
               state_in = ST_IDLE;
            end else begin
               prow_in  = qrow_ff[PIX_W-1:0];
               pcol_in  = qcol_ff[PIX_W-1:0];
               idx_in   = PROD_W'(qrow_ff[PIX_W-1:0]) * PROD_W'(w_eff) +
                          PROD_W'(qcol_ff[PIX_W-1:0]);
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = too_big ? ST_IDLE : ST_UPDATE;
         end
         ST_UPDATE: begin
            if (hit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{(RSP_DATA_W-2*PIX_W-IDX_W-OFS_W){1'b0}},
                                byte_full[OFS_W-1:0], idx_ff[IDX_W-1:0],
                                pcol_ff, prow_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         step_ff       <= STEP_RESET;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_STEP:   step_ff   <= csr_wdata;
               CSR_WIDTH:  width_ff  <= csr_wdata[SIDE_W-1:0];
               CSR_HEIGHT: height_ff <= csr_wdata[SIDE_W-1:0];
               CSR_NONE:   ;
               default:    ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff       <= div_in;
      qrow_ff      <= qrow_in;
      qcol_ff      <= qcol_in;
      rrow_ff      <= rrow_in;
      rcol_ff      <= rcol_in;
      prow_ff      <= prow_in;
      pcol_ff      <= pcol_in;
      idx_ff       <= idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // bitmap is written only by the clearing pass or when a pixel is first marked
   a_ram_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE))
      else $error("bitmap write outside clear or update");

   // a marked pixel always lies inside the bitmap
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (idx_ff < PROD_W'(MAX_PIXELS)))
      else $error("marked pixel beyond bitmap");

   // a bitmap read is always followed by its update step
   a_read_then_update: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> (state_ff == ST_UPDATE))
      else $error("bitmap read not followed by update");

   // a new result is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> !rsp_tvalid_ff || rsp_tready)
      else $error("result overwritten before taken");

endmodule
